// ----- rtl/core/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared widths, state codes and helper types for the BILOU Viterbi step.
// ----------------------------------------------------------------------------
package bvs_pkg;

    localparam int PROB_BITS   = 16;
    localparam int ENTITY_BITS = 8;
    localparam int NUM_STATES  = 5;
    localparam int CODE_BITS   = 3;

    typedef logic [PROB_BITS-1:0]   prob_t;
    typedef logic [ENTITY_BITS-1:0] ent_t;
    typedef logic [CODE_BITS-1:0]   code_t;

    localparam prob_t FULL = {PROB_BITS{1'b1}};

    // Tag state codes
    localparam code_t ST_B    = 3'd0;
    localparam code_t ST_I    = 3'd1;
    localparam code_t ST_L    = 3'd2;
    localparam code_t ST_O    = 3'd3;
    localparam code_t ST_U    = 3'd4;
    localparam code_t ST_NONE = 3'd5;

    // Divider handshake with the sequencer
    typedef struct packed {
        logic  start;
        prob_t small_val;
        prob_t large_val;
    } div_req_t;

    typedef struct packed {
        logic  done;
        prob_t quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/bvs_div.sv -----
// ----------------------------------------------------------------------------
// bvs_div
// Serial restoring divider: floor(small * FULL / large), one quotient bit
// per cycle. Requires small <= large and large != 0.
// ----------------------------------------------------------------------------
module bvs_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  bvs_pkg::div_req_t req,
    output bvs_pkg::div_rsp_t rsp
);
    import bvs_pkg::*;

    localparam int CNT_BITS = $clog2(PROB_BITS + 1);

    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic                   done_reg;
    logic                   done_next;
    prob_t                  rem_reg;
    prob_t                  rem_next;
    prob_t                  dvd_reg;
    prob_t                  dvd_next;
    prob_t                  quo_reg;
    prob_t                  quo_next;
    prob_t                  div_reg;
    prob_t                  div_next;
    logic [2*PROB_BITS-1:0] product_full;
    logic [PROB_BITS:0]     trial;
    logic [PROB_BITS:0]     diff;

    // Form small * FULL as (small << PROB_BITS) - small
    assign product_full = {req.small_val, {PROB_BITS{1'b0}}}
                          - {{PROB_BITS{1'b0}}, req.small_val};

    // Trial subtract for one quotient bit
    assign trial = {rem_reg, dvd_reg[PROB_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    // Load on start, then advance one bit per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            rem_next = product_full[2*PROB_BITS-1:PROB_BITS];
            dvd_next = product_full[PROB_BITS-1:0];
            div_next = req.large_val;
            cnt_next = CNT_BITS'(PROB_BITS);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[PROB_BITS-2:0], 1'b0};
            if (!diff[PROB_BITS])
            begin
                rem_next = diff[PROB_BITS-1:0];
                quo_next = {quo_reg[PROB_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PROB_BITS-1:0];
                quo_next = {quo_reg[PROB_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/bvs_mul.sv -----
// ----------------------------------------------------------------------------
// bvs_mul
// Shared Q0.16 multiplier with a registered result: (a * b) >> PROB_BITS.
// ----------------------------------------------------------------------------
module bvs_mul
(
    input  logic           clk,
    input  bvs_pkg::prob_t a,
    input  bvs_pkg::prob_t b,
    output bvs_pkg::prob_t p
);
    import bvs_pkg::*;

    logic [2*PROB_BITS-1:0] product;
    prob_t                  p_reg;

    assign product = a * b;

    // Register the upper half of the product
    always_ff @(posedge clk)
    begin
        p_reg <= product[2*PROB_BITS-1:PROB_BITS];
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/bilou_viterbi_step.sv -----
// ----------------------------------------------------------------------------
// bilou_viterbi_step
// One Viterbi step of a five-state BILOU tagger per request.
// ----------------------------------------------------------------------------
// A later token runs the serial divider (one quotient bit per cycle) and
// then the shared multiplier (one state per cycle); the divide is skipped
// when both compared paths are zero, and a first token skips both. A new
// request can be taken in the cycle after the result is loaded into the
// output register. Reset clears all path state.
module bilou_viterbi_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first_token,
    input  bvs_pkg::prob_t      prob_b,
    input  bvs_pkg::prob_t      prob_i,
    input  bvs_pkg::prob_t      prob_l,
    input  bvs_pkg::prob_t      prob_o,
    input  bvs_pkg::prob_t      prob_u,
    input  bvs_pkg::ent_t       ent_b,
    input  bvs_pkg::ent_t       ent_i,
    input  bvs_pkg::ent_t       ent_l,
    input  bvs_pkg::ent_t       ent_o,
    input  bvs_pkg::ent_t       ent_u,
    output logic                out_valid,
    input  logic                out_stall,
    output bvs_pkg::code_t      back_b,
    output bvs_pkg::code_t      back_i,
    output bvs_pkg::code_t      back_l,
    output bvs_pkg::code_t      back_o,
    output bvs_pkg::code_t      back_u,
    output bvs_pkg::code_t      best_state,
    output bvs_pkg::ent_t       carried_ent_i,
    output bvs_pkg::ent_t       carried_ent_l
);
    import bvs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    prob_t path_prob_reg [NUM_STATES];
    ent_t  path_ent_reg  [NUM_STATES];
    prob_t lp_reg        [NUM_STATES];
    ent_t  le_reg        [NUM_STATES];
    logic  first_reg;
    code_t bl_reg;
    code_t bb_reg;
    logic  b_larger_reg;
    prob_t sl_reg;
    prob_t sb_reg;
    code_t cnt_reg;

    logic  out_valid_reg;
    code_t back_b_reg;
    code_t back_i_reg;
    code_t back_l_reg;
    code_t back_o_reg;
    code_t back_u_reg;
    code_t best_reg;
    ent_t  cent_i_reg;
    ent_t  cent_l_reg;

    logic     accept;
    logic     load_out;
    code_t    bl_sel;
    code_t    bb_sel;
    prob_t    pl;
    prob_t    pb;
    logic     b_larger;
    logic     both_zero;
    code_t    best_sel;
    logic     use_bl;
    code_t    wr_idx;
    prob_t    mul_a;
    prob_t    mul_p;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Pick the best previous L/O/U and B/I, first one wins a tie
    always_comb
    begin
        bl_sel = ST_L;
        if (path_prob_reg[ST_O] > path_prob_reg[ST_L])
            bl_sel = ST_O;
        if (path_prob_reg[ST_U] > path_prob_reg[bl_sel])
            bl_sel = ST_U;
        bb_sel = (path_prob_reg[ST_I] > path_prob_reg[ST_B]) ? ST_I : ST_B;
    end

    assign pl        = path_prob_reg[bl_sel];
    assign pb        = path_prob_reg[bb_sel];
    assign b_larger  = (pb > pl);
    assign both_zero = !b_larger && (pl == '0);

    // Launch the normalization divide
    assign div_req.start     = (state_reg == S_SEL) && !first_reg && !both_zero;
    assign div_req.small_val = b_larger ? pl : pb;
    assign div_req.large_val = b_larger ? pb : pl;

    bvs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Feed one state per cycle into the shared multiplier
    assign use_bl = (cnt_reg == ST_B) || (cnt_reg == ST_O) || (cnt_reg == ST_U);
    assign mul_a  = use_bl ? sl_reg : sb_reg;
    assign wr_idx = cnt_reg - 1'b1;

    bvs_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   ((cnt_reg < CODE_BITS'(NUM_STATES)) ? lp_reg[cnt_reg] : '0),
        .p   (mul_p)
    );

    // Find the best path, earliest state wins a tie
    always_comb
    begin
        best_sel = ST_B;
        if (path_prob_reg[ST_I] > path_prob_reg[best_sel])
            best_sel = ST_I;
        if (path_prob_reg[ST_L] > path_prob_reg[best_sel])
            best_sel = ST_L;
        if (path_prob_reg[ST_O] > path_prob_reg[best_sel])
            best_sel = ST_O;
        if (path_prob_reg[ST_U] > path_prob_reg[best_sel])
            best_sel = ST_U;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SEL;
            end
            S_SEL:
            begin
                if (first_reg)
                    state_next = S_DONE;
                else if (both_zero)
                    state_next = S_MUL;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == CODE_BITS'(NUM_STATES))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and path state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int s = 0; s < NUM_STATES; s++)
            begin
                path_prob_reg[s] <= '0;
                path_ent_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result until taken
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_SEL)
            begin
                cnt_reg <= '0;
                if (first_reg)
                begin
                    path_prob_reg[ST_B] <= lp_reg[ST_B];
                    path_prob_reg[ST_I] <= '0;
                    path_prob_reg[ST_L] <= '0;
                    path_prob_reg[ST_O] <= lp_reg[ST_O];
                    path_prob_reg[ST_U] <= lp_reg[ST_U];
                    for (int s = 0; s < NUM_STATES; s++)
                        path_ent_reg[s] <= le_reg[s];
                end
                else
                begin
                    path_ent_reg[ST_B] <= le_reg[ST_B];
                    path_ent_reg[ST_I] <= path_ent_reg[bb_sel];
                    path_ent_reg[ST_L] <= path_ent_reg[bb_sel];
                    path_ent_reg[ST_O] <= le_reg[ST_O];
                    path_ent_reg[ST_U] <= le_reg[ST_U];
                end
            end
            else if (state_reg == S_MUL)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != '0)
                    path_prob_reg[wr_idx] <= mul_p;
            end
        end
    end

    // Request capture and per-token working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg    <= first_token;
            lp_reg[ST_B] <= prob_b;
            lp_reg[ST_I] <= prob_i;
            lp_reg[ST_L] <= prob_l;
            lp_reg[ST_O] <= prob_o;
            lp_reg[ST_U] <= prob_u;
            le_reg[ST_B] <= ent_b;
            le_reg[ST_I] <= ent_i;
            le_reg[ST_L] <= ent_l;
            le_reg[ST_O] <= ent_o;
            le_reg[ST_U] <= ent_u;
        end
        if (state_reg == S_SEL)
        begin
            bl_reg       <= bl_sel;
            bb_reg       <= bb_sel;
            b_larger_reg <= b_larger;
            sl_reg       <= FULL;
            sb_reg       <= FULL;
        end
        // Scale the smaller path by the divider result
        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            if (b_larger_reg)
                sl_reg <= div_rsp.quotient;
            else
                sb_reg <= div_rsp.quotient;
        end
        if (load_out)
        begin
            back_b_reg <= first_reg ? ST_NONE : bl_reg;
            back_i_reg <= first_reg ? ST_NONE : bb_reg;
            back_l_reg <= first_reg ? ST_NONE : bb_reg;
            back_o_reg <= first_reg ? ST_NONE : bl_reg;
            back_u_reg <= first_reg ? ST_NONE : bl_reg;
            best_reg   <= best_sel;
            cent_i_reg <= path_ent_reg[ST_I];
            cent_l_reg <= path_ent_reg[ST_L];
        end
    end

    assign out_valid     = out_valid_reg;
    assign back_b        = back_b_reg;
    assign back_i        = back_i_reg;
    assign back_l        = back_l_reg;
    assign back_o        = back_o_reg;
    assign back_u        = back_u_reg;
    assign best_state    = best_reg;
    assign carried_ent_i = cent_i_reg;
    assign carried_ent_l = cent_l_reg;

    // An accepted request always moves to path selection
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_SEL)
        else $error("accepted request did not start selection");

    // The divider only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    // During multiply the larger path is at full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> (sl_reg == FULL) || (sb_reg == FULL))
        else $error("neither scale factor is full scale");

    // A result holds a real best state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> best_state <= ST_U)
        else $error("best state code out of range");

endmodule
